// File: sv/det_pkg.sv
// Package for the divergence episode tracker.
// Holds default widths, register indexes, the phase type and the configuration struct.
// Depends on nothing; every other file imports it.
`default_nettype none

package det_pkg;

    localparam int DEF_TICK_BITS  = 32;
    localparam int DEF_RUN_BITS   = 16;
    localparam int DEF_SCORE_BITS = 32;

    localparam int THR_BITS      = 32;
    localparam int LIMIT_BITS    = 16;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 2;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [THR_BITS-1:0]   THRESHOLD_RST  = 32'd65536;
    localparam logic [LIMIT_BITS-1:0] HYSTERESIS_RST = 16'd3;
    localparam logic [LIMIT_BITS-1:0] CHRONIC_RST    = 16'd10;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_HYSTERESIS = 2'd1,
        REG_CHRONIC    = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_NORMAL     = 3'd0,
        PH_DIVERGING  = 3'd1,
        PH_CHRONIC    = 3'd2,
        PH_CONVERGING = 3'd3,
        PH_CONVERGED  = 3'd4
    } phase_t;

    typedef struct packed {
        logic signed [THR_BITS-1:0] threshold;
        logic [LIMIT_BITS-1:0]      hyst_limit;
        logic [LIMIT_BITS-1:0]      chronic_limit;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/det_cfg.sv
// Configuration register file of the divergence episode tracker.
// Takes register writes and presents the settings as one struct; uses det_pkg.
`default_nettype none

module det_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [det_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [det_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output det_pkg::cfg_t                           cfg
);
    import det_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESHOLD:  cfg_next.threshold = $signed(cfg_data[THR_BITS-1:0]);
                REG_HYSTERESIS: cfg_next.hyst_limit = cfg_data[LIMIT_BITS-1:0];
                REG_CHRONIC:    cfg_next.chronic_limit = cfg_data[LIMIT_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold     <= $signed(THRESHOLD_RST);
            cfg_reg.hyst_limit    <= HYSTERESIS_RST;
            cfg_reg.chronic_limit <= CHRONIC_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/det_front.sv
// Front end of the divergence episode tracker.
// Accepts readings, classifies each against the threshold and pushes it to the queue.
// Uses det_pkg.
`default_nettype none

module det_front #(
    parameter int TICK_BITS  = det_pkg::DEF_TICK_BITS,
    parameter int SCORE_BITS = det_pkg::DEF_SCORE_BITS
) (
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire logic [TICK_BITS-1:0]               tick,
    input  wire logic signed [SCORE_BITS-1:0]       score,
    input  wire logic signed [det_pkg::THR_BITS-1:0] threshold,
    input  wire logic                               q_full,
    output logic                                    push,
    output logic [TICK_BITS+SCORE_BITS:0]           push_data
);
    import det_pkg::*;

    localparam int CMP_BITS = (SCORE_BITS > THR_BITS) ? SCORE_BITS : THR_BITS;

    logic signed [CMP_BITS-1:0] score_ext;
    logic signed [CMP_BITS-1:0] thr_ext;
    logic                       above;

    assign score_ext  = CMP_BITS'(score);
    assign thr_ext    = CMP_BITS'(threshold);
    assign above      = (score_ext >= thr_ext);
    assign item_stall = q_full;
    assign push       = item_valid && !item_stall;
    assign push_data  = {above, score, tick};

endmodule

`default_nettype wire

// File: sv/det_queue.sv
// Short queue between the front and back ends of the divergence episode tracker.
// Holds classified readings in a small register array; uses det_pkg for its default depth.
`default_nettype none

module det_queue #(
    parameter int DATA_BITS = 65,
    parameter int DEPTH     = det_pkg::QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [DATA_BITS-1:0] push_data,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      not_empty,
    output logic [DATA_BITS-1:0]      head
);
    import det_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg;
    logic [PTR_BITS-1:0]  wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg;
    logic [PTR_BITS-1:0]  rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  count_next;
    logic                 do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/det_back.sv
// Back end of the divergence episode tracker.
// Runs the run counters, the phase machine and the episode records, and holds the report.
// Uses det_pkg.
`default_nettype none

module det_back #(
    parameter int TICK_BITS  = det_pkg::DEF_TICK_BITS,
    parameter int RUN_BITS   = det_pkg::DEF_RUN_BITS,
    parameter int SCORE_BITS = det_pkg::DEF_SCORE_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire det_pkg::cfg_t                cfg,
    input  wire logic                         q_valid,
    input  wire logic [TICK_BITS+SCORE_BITS:0] q_data,
    output logic                              q_pop,
    output logic                              rpt_valid,
    input  wire logic                         rpt_stall,
    output logic [2:0]                        phase,
    output logic                              converged,
    output logic [TICK_BITS-1:0]              start_tick,
    output logic [TICK_BITS-1:0]              settle_tick,
    output logic [TICK_BITS-1:0]              converge_span,
    output logic signed [SCORE_BITS-1:0]      peak_score,
    output logic signed [SCORE_BITS-1:0]      latest_score
);
    import det_pkg::*;

    localparam int RC_BITS = (RUN_BITS > LIMIT_BITS) ? RUN_BITS : LIMIT_BITS;

    logic [TICK_BITS-1:0]         in_tick;
    logic signed [SCORE_BITS-1:0] in_score;
    logic                         in_above;

    phase_t                       phase_reg;
    phase_t                       phase_next;
    logic [RUN_BITS-1:0]          above_run_reg;
    logic [RUN_BITS-1:0]          above_run_next;
    logic [RUN_BITS-1:0]          below_run_reg;
    logic [RUN_BITS-1:0]          below_run_next;
    logic [TICK_BITS-1:0]         start_reg;
    logic [TICK_BITS-1:0]         start_next;
    logic [TICK_BITS-1:0]         end_reg;
    logic [TICK_BITS-1:0]         end_next;
    logic signed [SCORE_BITS-1:0] peak_reg;
    logic signed [SCORE_BITS-1:0] peak_next;
    logic signed [SCORE_BITS-1:0] last_reg;
    logic                         valid_reg;
    logic                         valid_next;

    logic hyst_met;
    logic chronic_met;
    logic new_episode;
    logic settle_set;
    logic settle_clear;

    assign in_tick  = q_data[TICK_BITS-1:0];
    assign in_score = $signed(q_data[TICK_BITS+SCORE_BITS-1:TICK_BITS]);
    assign in_above = q_data[TICK_BITS+SCORE_BITS];

    assign q_pop = q_valid && (!valid_reg || !rpt_stall);

    always_comb
    begin
        if (in_above)
        begin
            above_run_next = (above_run_reg == '1) ? above_run_reg : above_run_reg + 1'b1;
            below_run_next = '0;
        end
        else
        begin
            above_run_next = '0;
            below_run_next = (below_run_reg == '1) ? below_run_reg : below_run_reg + 1'b1;
        end
    end

    assign hyst_met    = (RC_BITS'(below_run_next) >= RC_BITS'(cfg.hyst_limit));
    assign chronic_met = (RC_BITS'(above_run_next) >= RC_BITS'(cfg.chronic_limit));

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_NORMAL:
            begin
                if (in_above)
                begin
                    phase_next = PH_DIVERGING;
                end
            end
            PH_DIVERGING:
            begin
                if (!in_above && hyst_met)
                begin
                    phase_next = PH_CONVERGED;
                end
                else if (chronic_met)
                begin
                    phase_next = PH_CHRONIC;
                end
            end
            PH_CHRONIC:
            begin
                if (!in_above)
                begin
                    phase_next = PH_CONVERGING;
                end
            end
            PH_CONVERGING:
            begin
                if (in_above)
                begin
                    phase_next = PH_CHRONIC;
                end
                else if (hyst_met)
                begin
                    phase_next = PH_CONVERGED;
                end
            end
            PH_CONVERGED:
            begin
                if (in_above)
                begin
                    phase_next = PH_DIVERGING;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        new_episode  = 1'b0;
        settle_set   = 1'b0;
        settle_clear = 1'b0;
        case (phase_reg)
            PH_NORMAL:
            begin
                new_episode = in_above;
            end
            PH_DIVERGING, PH_CONVERGING:
            begin
                settle_set = !in_above && hyst_met;
            end
            PH_CONVERGED:
            begin
                new_episode  = in_above;
                settle_clear = in_above;
            end
            default:
            begin
                new_episode = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        start_next = new_episode ? in_tick : start_reg;
        if (settle_set)
        begin
            end_next = in_tick;
        end
        else if (settle_clear)
        begin
            end_next = '0;
        end
        else
        begin
            end_next = end_reg;
        end
        if (new_episode || (in_score > peak_reg))
        begin
            peak_next = in_score;
        end
        else
        begin
            peak_next = peak_reg;
        end
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && rpt_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NORMAL;
            above_run_reg <= '0;
            below_run_reg <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            peak_reg      <= '0;
            last_reg      <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                above_run_reg <= above_run_next;
                below_run_reg <= below_run_next;
                start_reg     <= start_next;
                end_reg       <= end_next;
                peak_reg      <= peak_next;
                last_reg      <= in_score;
            end
        end
    end

    assign rpt_valid    = valid_reg;
    assign phase        = phase_reg;
    assign converged    = (phase_reg == PH_CONVERGED);
    assign start_tick   = start_reg;
    assign settle_tick  = end_reg;
    assign peak_score   = peak_reg;
    assign latest_score = last_reg;

    always_comb
    begin
        if ((end_reg == '0) || (start_reg == '0) || (end_reg <= start_reg))
        begin
            converge_span = '0;
        end
        else
        begin
            converge_span = end_reg - start_reg;
        end
    end

endmodule

`default_nettype wire

// File: sv/divergence_episode_tracker.sv
// Top level of the divergence episode tracker.
// Connects det_cfg, det_front, det_queue and det_back; uses det_pkg.
//
//  channel   handshake             payload
//  item      item_valid/item_stall tick, score
//  report    rpt_valid/rpt_stall   phase, converged, start_tick, settle_tick,
//                                  converge_span, peak_score, latest_score
//  config    cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One reading is accepted per cycle while item_stall is low; its report is registered as
// the back end takes it, so the sustained rate is one reading per clock while no report
// stall holds it. A two-entry queue separates front and back, and the report register
// lets the back end pop a new reading as a waiting report is taken. A held report stall
// fills the queue and then raises item_stall. Reset spares only the queue storage.
`default_nettype none

module divergence_episode_tracker #(
    parameter int TICK_BITS  = det_pkg::DEF_TICK_BITS,
    parameter int RUN_BITS   = det_pkg::DEF_RUN_BITS,
    parameter int SCORE_BITS = det_pkg::DEF_SCORE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [det_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [det_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic [TICK_BITS-1:0]              tick,
    input  wire logic signed [SCORE_BITS-1:0]      score,
    output logic                                   rpt_valid,
    input  wire logic                              rpt_stall,
    output logic [2:0]                             phase,
    output logic                                   converged,
    output logic [TICK_BITS-1:0]                   start_tick,
    output logic [TICK_BITS-1:0]                   settle_tick,
    output logic [TICK_BITS-1:0]                   converge_span,
    output logic signed [SCORE_BITS-1:0]           peak_score,
    output logic signed [SCORE_BITS-1:0]           latest_score
);
    import det_pkg::*;

    localparam int ITEM_BITS = TICK_BITS + SCORE_BITS + 1;

    cfg_t                 cfg;
    logic                 q_full;
    logic                 q_not_empty;
    logic                 push;
    logic                 pop;
    logic [ITEM_BITS-1:0] push_data;
    logic [ITEM_BITS-1:0] head;

    det_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    det_front #(
        .TICK_BITS  (TICK_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .tick       (tick),
        .score      (score),
        .threshold  (cfg.threshold),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    det_queue #(
        .DATA_BITS (ITEM_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    det_back #(
        .TICK_BITS  (TICK_BITS),
        .RUN_BITS   (RUN_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_not_empty),
        .q_data        (head),
        .q_pop         (pop),
        .rpt_valid     (rpt_valid),
        .rpt_stall     (rpt_stall),
        .phase         (phase),
        .converged     (converged),
        .start_tick    (start_tick),
        .settle_tick   (settle_tick),
        .converge_span (converge_span),
        .peak_score    (peak_score),
        .latest_score  (latest_score)
    );

endmodule

`default_nettype wire

// File: sv/det_checker.sv
// Port-level checker for the divergence episode tracker and the bind that attaches it.
// Watches the report channel only; uses det_pkg.
`default_nettype none

module det_checker #(
    parameter int TICK_BITS  = det_pkg::DEF_TICK_BITS,
    parameter int SCORE_BITS = det_pkg::DEF_SCORE_BITS
) (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         rpt_valid,
    input wire logic                         rpt_stall,
    input wire logic [2:0]                   phase,
    input wire logic                         converged,
    input wire logic [TICK_BITS-1:0]         start_tick,
    input wire logic [TICK_BITS-1:0]         settle_tick,
    input wire logic [TICK_BITS-1:0]         converge_span,
    input wire logic signed [SCORE_BITS-1:0] peak_score,
    input wire logic signed [SCORE_BITS-1:0] latest_score
);
    import det_pkg::*;

    // A report that is held back must stay offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt_stall |=> rpt_valid)
        else $error("report dropped while stalled");

    // The converged flag follows the phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> (converged == (phase == PH_CONVERGED)))
        else $error("converged flag disagrees with phase");

    // A settle tick is only recorded once the episode has converged.
    assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !converged |-> (settle_tick == '0))
        else $error("settle tick set outside the converged phase");

    // The episode duration is the settle tick minus the start tick when both are set and the settle tick is later.
    assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && (start_tick != '0) && (settle_tick > start_tick)
        |-> (converge_span == settle_tick - start_tick))
        else $error("episode duration is wrong");

    // The episode peak never falls below the latest score.
    assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> (peak_score >= latest_score))
        else $error("peak score below latest score");

endmodule

bind divergence_episode_tracker det_checker #(
    .TICK_BITS  (TICK_BITS),
    .SCORE_BITS (SCORE_BITS)
) u_det_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rpt_valid     (rpt_valid),
    .rpt_stall     (rpt_stall),
    .phase         (phase),
    .converged     (converged),
    .start_tick    (start_tick),
    .settle_tick   (settle_tick),
    .converge_span (converge_span),
    .peak_score    (peak_score),
    .latest_score  (latest_score)
);

`default_nettype wire

// File: bench/tb_divergence_episode_tracker.sv
// Self-checking bench for divergence_episode_tracker: a predictor class models the phase
// machine, run counters, episode ticks and peak score, and checks every report in order.
// Depends on det_pkg and the divergence_episode_tracker RTL.
module tb_divergence_episode_tracker;
    import det_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam logic [LIMIT_BITS-1:0] RUN_TOP = '1;
    localparam logic signed [31:0] SCORE_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SCORE_MIN = 32'sh80000000;

    typedef struct packed {
        phase_t             phase;
        logic               converged;
        logic [31:0]        start_tick;
        logic [31:0]        settle_tick;
        logic [31:0]        converge_span;
        logic signed [31:0] peak_score;
        logic signed [31:0] latest_score;
    } report_t;

    class episode_tracker_model;
        logic signed [31:0]    thr;
        logic [LIMIT_BITS-1:0] hyst_need;
        logic [LIMIT_BITS-1:0] chronic_need;
        phase_t                ph;
        logic [LIMIT_BITS-1:0] above_run;
        logic [LIMIT_BITS-1:0] below_run;
        logic [31:0]           ep_start;
        logic [31:0]           ep_end;
        logic signed [31:0]    peak;
        logic signed [31:0]    latest;
        report_t               pending_reports[$];
        int                    mismatches;

        function new();
            thr = THRESHOLD_RST;
            hyst_need = HYSTERESIS_RST;
            chronic_need = CHRONIC_RST;
            ph = PH_NORMAL;
            above_run = '0;
            below_run = '0;
            ep_start = '0;
            ep_end = '0;
            peak = '0;
            latest = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
            case (idx)
                REG_THRESHOLD:  thr = data;
                REG_HYSTERESIS: hyst_need = data[LIMIT_BITS-1:0];
                REG_CHRONIC:    chronic_need = data[LIMIT_BITS-1:0];
                default:        ;
            endcase
        endfunction

        function void take_reading(logic [31:0] t, logic signed [31:0] s);
            bit      above;
            bit      fresh;
            report_t r;
            above = (s >= thr);
            fresh = 1'b0;
            latest = s;
            if (s > peak)
            begin
                peak = s;
            end
            if (above)
            begin
                if (above_run != RUN_TOP)
                begin
                    above_run++;
                end
                below_run = '0;
            end
            else
            begin
                if (below_run != RUN_TOP)
                begin
                    below_run++;
                end
                above_run = '0;
            end
            case (ph)
                PH_NORMAL:
                begin
                    fresh = above;
                end
                PH_DIVERGING:
                begin
                    if (!above && below_run >= hyst_need)
                    begin
                        ph = PH_CONVERGED;
                        ep_end = t;
                    end
                    else if (above_run >= chronic_need)
                    begin
                        ph = PH_CHRONIC;
                    end
                end
                PH_CHRONIC:
                begin
                    if (!above)
                    begin
                        ph = PH_CONVERGING;
                    end
                end
                PH_CONVERGING:
                begin
                    if (above)
                    begin
                        ph = PH_CHRONIC;
                    end
                    else if (below_run >= hyst_need)
                    begin
                        ph = PH_CONVERGED;
                        ep_end = t;
                    end
                end
                PH_CONVERGED:
                begin
                    if (above)
                    begin
                        fresh = 1'b1;
                        ep_end = '0;
                    end
                end
                default: ;
            endcase
            if (fresh)
            begin
                ph = PH_DIVERGING;
                ep_start = t;
                peak = s;
            end
            r.phase = ph;
            r.converged = (ph == PH_CONVERGED);
            r.start_tick = ep_start;
            r.settle_tick = ep_end;
            if (ep_end == 0 || ep_start == 0 || ep_end <= ep_start)
            begin
                r.converge_span = '0;
            end
            else
            begin
                r.converge_span = ep_end - ep_start;
            end
            r.peak_score = peak;
            r.latest_score = latest;
            pending_reports.push_back(r);
        endfunction

        function void match_report(report_t got);
            report_t want;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected report: phase %0d start %h settle %h", got.phase,
                             got.start_tick, got.settle_tick);
                end
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("report mismatch (expected/actual): phase %0d/%0d conv %b/%b",
                                 want.phase, got.phase, want.converged, got.converged);
                        $display("  start %h/%h settle %h/%h ttc %h/%h", want.start_tick,
                                 got.start_tick, want.settle_tick, got.settle_tick,
                                 want.converge_span, got.converge_span);
                        $display("  peak %h/%h latest %h/%h", want.peak_score,
                                 got.peak_score, want.latest_score, got.latest_score);
                    end
                end
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      item_valid = 1'b0;
    logic                      item_stall;
    logic [31:0]               tick_in = '0;
    logic signed [31:0]        score_in = '0;
    logic                      rpt_valid;
    logic                      rpt_stall = 1'b0;
    logic [2:0]                phase;
    logic                      converged;
    logic [31:0]               start_tick;
    logic [31:0]               settle_tick;
    logic [31:0]               converge_span;
    logic signed [31:0]        peak_score;
    logic signed [31:0]        latest_score;

    bit                        calm = 1'b0;
    int                        cycles = 0;
    logic signed [31:0]        thr_now = THRESHOLD_RST;
    logic [LIMIT_BITS-1:0]     hyst_now = HYSTERESIS_RST;
    logic [LIMIT_BITS-1:0]     chron_now = CHRONIC_RST;
    logic [31:0]               next_tick = 32'd1000;
    episode_tracker_model      model = new();

    divergence_episode_tracker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .tick          (tick_in),
        .score         (score_in),
        .rpt_valid     (rpt_valid),
        .rpt_stall     (rpt_stall),
        .phase         (phase),
        .converged     (converged),
        .start_tick    (start_tick),
        .settle_tick   (settle_tick),
        .converge_span (converge_span),
        .peak_score    (peak_score),
        .latest_score  (latest_score)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("tb_divergence_episode_tracker: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin : monitor
        report_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                model.write_reg(cfg_index, cfg_data);
            end
            if (item_valid && !item_stall)
            begin
                model.take_reading(tick_in, score_in);
            end
            if (rpt_valid && !rpt_stall)
            begin
                got.phase = phase_t'(phase);
                got.converged = converged;
                got.start_tick = start_tick;
                got.settle_tick = settle_tick;
                got.converge_span = converge_span;
                got.peak_score = peak_score;
                got.latest_score = latest_score;
                model.match_report(got);
            end
        end
    end

    initial
    begin : report_sink
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 16);
            if (hold > 0)
            begin
                rpt_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rpt_stall <= 1'b0;
            do @(posedge clk); while (!rpt_valid);
        end
    end

    task automatic send_reading(input logic [31:0] t, input logic signed [31:0] s);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        tick_in <= t;
        score_in <= s;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic settle_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (model.pending_reports.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apply_settings(input logic signed [31:0] thr, input logic [31:0] hyst,
                                  input logic [31:0] chron, input bit spare);
        logic [CFG_IDX_BITS-1:0] idx [4];
        logic [31:0]             val [4];
        int                      n;
        idx[0] = REG_THRESHOLD;
        idx[1] = REG_HYSTERESIS;
        idx[2] = REG_CHRONIC;
        idx[3] = REG_SPARE;
        val[0] = thr;
        val[1] = hyst;
        val[2] = chron;
        val[3] = $urandom;
        n = spare ? 4 : 3;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        thr_now = thr;
        hyst_now = hyst[LIMIT_BITS-1:0];
        chron_now = chron[LIMIT_BITS-1:0];
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] score_near(logic signed [31:0] thr, bit up);
        longint      v;
        int unsigned span;
        span = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4 * 65536);
        if (up)
        begin
            v = longint'(thr) + longint'(span);
            if (v > longint'(SCORE_MAX))
            begin
                v = longint'(SCORE_MAX);
            end
        end
        else if (thr == SCORE_MIN)
        begin
            v = longint'(thr);
        end
        else
        begin
            v = longint'(thr) - 1 - longint'(span);
            if (v < longint'(SCORE_MIN))
            begin
                v = longint'(SCORE_MIN);
            end
        end
        return v[31:0];
    endfunction

    task automatic run_episodes(input int count);
        int                 sent;
        int                 len;
        bit                 up;
        logic [31:0]        t;
        logic signed [31:0] s;
        sent = 0;
        up = 1'b1;
        while (sent < count)
        begin
            len = up ? $urandom_range(1, chron_now + 2) : $urandom_range(1, hyst_now + 2);
            repeat (len)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    s = $urandom;
                end
                else
                begin
                    s = score_near(thr_now, up);
                end
                next_tick = next_tick + $urandom_range(1, 5);
                case ($urandom_range(0, 39))
                    0:       t = '0;
                    1, 2:    t = $urandom;
                    default: t = next_tick;
                endcase
                send_reading(t, s);
                sent++;
            end
            up = !up;
        end
    endtask

    initial
    begin : stimulus
        logic signed [31:0] thr;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_reading(32'd0, SCORE_MAX);
        send_reading(32'd1, SCORE_MIN);
        send_reading(32'd2, 32'sh0000FFFF);
        send_reading(32'd3, 32'sh0);
        send_reading(32'd4, 32'sh00010000);
        for (int i = 5; i <= 13; i++)
        begin
            send_reading(i, 32'sh00010000 + i * 32'sh1000);
        end
        send_reading(32'd14, -32'sd1);
        send_reading(32'd15, 32'sh00020000);
        send_reading(32'd16, 32'sh0);
        send_reading(32'd17, 32'sh0);
        send_reading(32'd18, 32'sh0);
        send_reading(32'hFFFFFFFF, SCORE_MAX);
        send_reading(32'd5, 32'sh0);
        send_reading(32'd6, 32'sh0);
        send_reading(32'd7, 32'sh0);
        settle_idle();

        apply_settings(32'sh0, 32'hFFFF0000, 32'hABCD0000, 1'b1);
        send_reading(32'd100, 32'sd1);
        send_reading(32'd101, 32'sd0);
        send_reading(32'd102, -32'sd5);
        send_reading(32'd103, -32'sd5);
        send_reading(32'd104, 32'sd9);
        send_reading(32'd105, -32'sd1);
        settle_idle();

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0:       thr = THRESHOLD_RST;
                1:       thr = $urandom;
                2:       thr = $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
                default: thr = '0;
            endcase
            apply_settings(thr, ($urandom & 32'hFFFF0000) | $urandom_range(0, 6),
                           ($urandom & 32'hFFFF0000) | $urandom_range(0, 12), p == 5);
            calm = (p % 3 == 1);
            run_episodes(130);
            settle_idle();
        end
        calm = 1'b0;

        repeat (10) @(posedge clk);
        if (model.mismatches == 0)
        begin
            $display("tb_divergence_episode_tracker: PASS");
        end
        else
        begin
            $display("tb_divergence_episode_tracker: FAIL");
        end
        $finish;
    end
endmodule
